>>> sv/lse_pkg.sv
package lse_pkg;

    localparam int DATA_W       = 32;
    localparam int CNT_W        = 7;
    localparam int CMD_W        = 3;
    localparam int STAT_W       = 2;
    localparam int RESULT_LIMIT = 64;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TOP3   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POPN   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BOT3   = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_SHORT = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]         op;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         count;
    } t_cmd;

endpackage

>>> sv/lse_ram.sv
module lse_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/lse_front.sv
module lse_front import lse_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [DATA_W-1:0] i_push_value,
    input  logic [CNT_W-1:0]         i_pop_count,
    output logic                     o_q_valid,
    input  logic                     i_q_ready,
    output t_cmd                     o_q
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       cmd_ok, push, pop;
    t_cmd       item;

    assign cmd_ok = (i_command <= CMD_BOT3);
    assign o_ready = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q = r_q[r_rp];
    assign push = i_valid && o_ready && cmd_ok;
    assign pop = o_q_valid && i_q_ready;

    always_comb begin
        item.op = i_command;
        item.value = i_push_value;
        // pop-several is capped at the result limit
        item.count = (i_pop_count > CNT_W'(RESULT_LIMIT)) ? CNT_W'(RESULT_LIMIT) : i_pop_count;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

`ifndef SYNTHESIS
    a_drop_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_valid && o_ready && !cmd_ok && !pop)
        |-> r_cnt == $past(r_cnt))
        else $error("unused command code entered the queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_cnt == 2'd0) && !$past(push) |-> r_cnt == 2'd0)
        else $error("queue count moved without an item");
`endif

endmodule

>>> sv/lse_back.sv
module lse_back import lse_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_ready,
    input  t_cmd                         i_q,
    output logic                         o_we,
    output logic [$clog2(DEPTH)-1:0]     o_waddr,
    output logic [DATA_W-1:0]            o_wdata,
    output logic                         o_re,
    output logic [$clog2(DEPTH)-1:0]     o_raddr,
    input  logic [DATA_W-1:0]            i_rdata,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [STAT_W-1:0]            o_status,
    output logic signed [DATA_W-1:0]     o_data,
    output logic                         o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CMD_W-1:0]  r_op, n_op;
    logic [DATA_W-1:0] r_value, n_value;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [FW-1:0]     r_fill, n_fill;
    logic              r_rd_last, n_rd_last;
    logic              r_res_valid, n_res_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [DATA_W-1:0] r_data, n_data;
    logic              r_last, n_last;

    logic              can_load, ld, ld_last;
    logic [STAT_W-1:0] ld_status;
    logic [DATA_W-1:0] ld_data;
    logic              full, lt3;

    assign can_load = !r_res_valid || i_res_ready;
    assign full = (r_fill == FW'(DEPTH));
    assign lt3 = (r_fill < FW'(3));

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_value = r_value;
        n_rem = r_rem;
        n_ptr = r_ptr;
        n_fill = r_fill;
        n_rd_last = r_rd_last;
        o_q_ready = 1'b0;
        o_we = 1'b0;
        o_waddr = AW'(r_fill);
        o_wdata = r_value;
        o_re = 1'b0;
        o_raddr = '0;
        ld = 1'b0;
        ld_status = ST_OK;
        ld_data = '0;
        ld_last = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    n_op = i_q.op;
                    n_value = i_q.value;
                    n_state = S_EXEC;
                    if (i_q.op == CMD_LIST) begin
                        n_rem = (32'(r_fill) >= 32'(RESULT_LIMIT)) ? CNT_W'(RESULT_LIMIT)
                                                                   : CNT_W'(r_fill);
                        n_ptr = AW'(r_fill - FW'(1));
                    end else begin
                        n_rem = i_q.count;
                    end
                end
            end
            S_EXEC: begin
                unique case (r_op) inside
                    CMD_PUSH: begin
                        if (can_load) begin
                            ld = 1'b1;
                            n_state = S_IDLE;
                            if (full) begin
                                ld_status = ST_FULL;
                            end else begin
                                o_we = 1'b1;
                                n_fill = r_fill + FW'(1);
                            end
                        end
                    end
                    CMD_POP: begin
                        if (r_fill == '0) begin
                            if (can_load) begin
                                ld = 1'b1;
                                ld_status = ST_EMPTY;
                                n_state = S_IDLE;
                            end
                        end else begin
                            o_re = 1'b1;
                            o_raddr = AW'(r_fill - FW'(1));
                            n_fill = r_fill - FW'(1);
                            n_rd_last = 1'b1;
                            n_state = S_READ;
                        end
                    end
                    CMD_LIST: begin
                        if (r_rem == '0) begin
                            if (can_load) begin
                                ld = 1'b1;
                                ld_status = ST_EMPTY;
                                n_state = S_IDLE;
                            end
                        end else begin
                            o_re = 1'b1;
                            o_raddr = r_ptr;
                            n_ptr = r_ptr - AW'(1);
                            n_rem = r_rem - CNT_W'(1);
                            n_rd_last = (r_rem == CNT_W'(1));
                            n_state = S_READ;
                        end
                    end
                    CMD_TOP3, CMD_BOT3: begin
                        if (lt3) begin
                            if (can_load) begin
                                ld = 1'b1;
                                ld_status = ST_SHORT;
                                n_state = S_IDLE;
                            end
                        end else begin
                            o_re = 1'b1;
                            o_raddr = (r_op == CMD_TOP3) ? AW'(r_fill - FW'(3)) : AW'(2);
                            n_rd_last = 1'b1;
                            n_state = S_READ;
                        end
                    end
                    CMD_POPN: begin
                        if (r_rem == '0) begin
                            n_state = S_IDLE;
                        end else if (r_fill == '0) begin
                            if (can_load) begin
                                ld = 1'b1;
                                ld_status = ST_EMPTY;
                                ld_last = (r_rem == CNT_W'(1));
                                n_rem = r_rem - CNT_W'(1);
                                if (r_rem == CNT_W'(1)) begin
                                    n_state = S_IDLE;
                                end
                            end
                        end else begin
                            o_re = 1'b1;
                            o_raddr = AW'(r_fill - FW'(1));
                            n_fill = r_fill - FW'(1);
                            n_rem = r_rem - CNT_W'(1);
                            n_rd_last = (r_rem == CNT_W'(1));
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_READ: begin
                if (can_load) begin
                    ld = 1'b1;
                    ld_data = i_rdata;
                    ld_last = r_rd_last;
                    n_state = r_rd_last ? S_IDLE : S_EXEC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res_valid = r_res_valid && !i_res_ready;
        n_status = r_status;
        n_data = r_data;
        n_last = r_last;
        if (ld) begin
            n_res_valid = 1'b1;
            n_status = ld_status;
            n_data = ld_data;
            n_last = ld_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_res_valid <= 1'b0;
            r_rem <= '0;
        end else begin
            r_state <= n_state;
            r_fill <= n_fill;
            r_res_valid <= n_res_valid;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        r_value <= n_value;
        r_ptr <= n_ptr;
        r_rd_last <= n_rd_last;
        r_status <= n_status;
        r_data <= n_data;
        r_last <= n_last;
    end

    assign o_res_valid = r_res_valid;
    assign o_status = r_status;
    assign o_data = r_data;
    assign o_last = r_last;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count beyond depth");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_we) |-> r_fill == $past(r_fill) + FW'(1))
        else $error("write without fill increment");
    a_read_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_state == S_READ
        |-> ($past(r_state) == S_EXEC || $past(r_state) == S_READ))
        else $error("read wait entered from idle");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_status != ST_OK |-> r_data == '0)
        else $error("failed result carries data");
`endif

endmodule

>>> sv/lifo_stack_engine_top.sv
// Bounded LIFO stack of DEPTH signed 32-bit words. A front stage decodes each
// command item into a two-entry queue; the back stage executes it against a
// single-port-read RAM and a fill counter and drives a registered result
// port. Commands: push, pop, list (top to bottom, at most 64 results),
// peek third from top, pop several (count capped at 64), peek third from
// bottom; codes 6 and 7 are dropped without a result. Each command is first
// dequeued by the back stage; a result that needs no stored word (push
// acknowledge, failure status) is loaded from the execute state, while a
// result that reads a word first passes a read-wait state that covers the
// registered read of the entry RAM. Results with a non-ok status carry zero
// data; the final result of a command has last set.
module lifo_stack_engine_top import lse_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    output logic                     o_cmd_ready,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [DATA_W-1:0] i_push_value,
    input  logic [CNT_W-1:0]         i_pop_count,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_last
);

    localparam int AW = $clog2(DEPTH);

    logic              q_valid, q_ready;
    t_cmd              q_item;
    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    logic [DATA_W-1:0] wdata, rdata;

    lse_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_cmd_valid),
        .o_ready      (o_cmd_ready),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .i_pop_count  (i_pop_count),
        .o_q_valid    (q_valid),
        .i_q_ready    (q_ready),
        .o_q          (q_item)
    );

    lse_back #(.DEPTH(DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q         (q_item),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_status    (o_status),
        .o_data      (o_data),
        .o_last      (o_last)
    );

    lse_ram #(.W(DATA_W), .D(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

>>> sim/lifo_stack_engine_top_tb.sv
`timescale 1ns / 1ps

module lifo_stack_engine_top_tb;
    import lse_pkg::*;

    localparam int STACK_DEPTH = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 200;
    localparam int MAX_GAP     = 17;

    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]         op;
        logic signed [DATA_W-1:0] value;
        logic [CNT_W-1:0]         count;
        int                       gap;
        bit                       drain;
    } t_stack_cmd;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } t_stack_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cmd_valid;
    logic                     o_cmd_ready;
    logic [CMD_W-1:0]         i_command;
    logic signed [DATA_W-1:0] i_push_value;
    logic [CNT_W-1:0]         i_pop_count;
    logic                     o_res_valid;
    logic                     i_res_ready;
    logic [STAT_W-1:0]        o_status;
    logic signed [DATA_W-1:0] o_data;
    logic                     o_last;

    t_stack_cmd    cmd_q[$];
    t_stack_result pending_results[$];

    logic signed [DATA_W-1:0] shadow_mem [STACK_DEPTH];
    int                       shadow_fill = 0;

    bit cmd_acc   = 1'b0;
    bit res_acc   = 1'b0;
    bit stim_done = 1'b0;
    bit send_fast = 1'b0;
    int err_cnt   = 0;
    int cycle_cnt = 0;
    int rx_seen   = 0;
    int rx_wait   = 0;
    int rx_gap    = 0;
    int hold_left = 0;

    lifo_stack_engine_top #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_cmd_valid),
        .o_cmd_ready  (o_cmd_ready),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .i_pop_count  (i_pop_count),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_status     (o_status),
        .o_data       (o_data),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void add_result(logic [STAT_W-1:0] status,
                                       logic signed [DATA_W-1:0] data, logic last);
        t_stack_result r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    function automatic void stack_pop_one(logic last);
        if (shadow_fill == 0) begin
            add_result(ST_EMPTY, '0, last);
        end else begin
            shadow_fill = shadow_fill - 1;
            add_result(ST_OK, shadow_mem[shadow_fill], last);
        end
    endfunction

    function automatic void stack_apply(logic [CMD_W-1:0] op,
                                        logic signed [DATA_W-1:0] value,
                                        logic [CNT_W-1:0] count);
        int n;
        case (op)
            CMD_PUSH: begin
                if (shadow_fill >= STACK_DEPTH) begin
                    add_result(ST_FULL, '0, 1'b1);
                end else begin
                    shadow_mem[shadow_fill] = value;
                    shadow_fill = shadow_fill + 1;
                    add_result(ST_OK, '0, 1'b1);
                end
            end
            CMD_POP: begin
                stack_pop_one(1'b1);
            end
            CMD_LIST: begin
                if (shadow_fill == 0) begin
                    add_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    n = (shadow_fill < RESULT_LIMIT) ? shadow_fill : RESULT_LIMIT;
                    for (int i = 0; i < n; i++)
                        add_result(ST_OK, shadow_mem[shadow_fill - 1 - i], i == n - 1);
                end
            end
            CMD_TOP3: begin
                if (shadow_fill < 3)
                    add_result(ST_SHORT, '0, 1'b1);
                else
                    add_result(ST_OK, shadow_mem[shadow_fill - 3], 1'b1);
            end
            CMD_POPN: begin
                n = (int'(count) < RESULT_LIMIT) ? int'(count) : RESULT_LIMIT;
                for (int i = 0; i < n; i++)
                    stack_pop_one(i == n - 1);
            end
            CMD_BOT3: begin
                if (shadow_fill < 3)
                    add_result(ST_SHORT, '0, 1'b1);
                else
                    add_result(ST_OK, shadow_mem[2], 1'b1);
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_cmd(logic [CMD_W-1:0] op, logic signed [DATA_W-1:0] value,
                                      logic [CNT_W-1:0] count, bit drain);
        t_stack_cmd c;
        c.op    = op;
        c.value = value;
        c.count = count;
        c.drain = drain;
        c.gap   = send_fast ? 0 : $urandom_range(0, MAX_GAP);
        cmd_q.push_back(c);
    endfunction

    // command driver
    always @(negedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            i_cmd_valid <= 1'b0;
        end else if (i_cmd_valid && !cmd_acc) begin
            // item still on offer
        end else if (cmd_q.size() == 0) begin
            i_cmd_valid <= 1'b0;
            stim_done   <= 1'b1;
        end else if (cmd_q[0].gap > 0) begin
            i_cmd_valid <= 1'b0;
            cmd_q[0].gap = cmd_q[0].gap - 1;
        end else if (cmd_q[0].drain && pending_results.size() != 0) begin
            i_cmd_valid <= 1'b0;
        end else begin
            i_cmd_valid  <= 1'b1;
            i_command    <= cmd_q[0].op;
            i_push_value <= cmd_q[0].value;
            i_pop_count  <= cmd_q[0].count;
            void'(cmd_q.pop_front());
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            i_res_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_res_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (res_acc && (rx_seen == 40 || rx_seen == 250)) begin
            i_res_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
        end else if (res_acc) begin
            rx_gap = (((rx_seen / 32) % 3) == 1) ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_gap == 0) begin
                i_res_ready <= 1'b1;
            end else begin
                i_res_ready <= 1'b0;
                rx_wait     <= rx_gap - 1;
            end
        end else if (rx_wait > 0) begin
            i_res_ready <= 1'b0;
            rx_wait     <= rx_wait - 1;
        end else begin
            i_res_ready <= 1'b1;
        end
    end

    // predictor and result checker
    always @(posedge i_clk) begin
        t_stack_result want;
        cycle_cnt <= cycle_cnt + 1;
        cmd_acc   <= i_rst_n && i_cmd_valid && o_cmd_ready;
        res_acc   <= i_rst_n && o_res_valid && i_res_ready;
        if (i_rst_n && i_cmd_valid && o_cmd_ready)
            stack_apply(i_command, i_push_value, i_pop_count);
        if (i_rst_n && o_res_valid && i_res_ready) begin
            rx_seen <= rx_seen + 1;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d data %0d last %0b",
                         $time, o_status, o_data, o_last);
                err_cnt = err_cnt + 1;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, o_status);
                    err_cnt = err_cnt + 1;
                end
                if (o_data !== want.data) begin
                    $display("%0t: data mismatch: expected %0d, got %0d",
                             $time, want.data, o_data);
                    err_cnt = err_cnt + 1;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, want.last, o_last);
                    err_cnt = err_cnt + 1;
                end
            end
        end
    end

    initial begin
        int pushes;
        int counted;
        int r;
        logic [CNT_W-1:0] cnt;

        i_rst_n      = 1'b0;
        i_cmd_valid  = 1'b0;
        i_command    = CMD_PUSH;
        i_push_value = '0;
        i_pop_count  = '0;
        i_res_ready  = 1'b0;

        // directed: empty stack, reserved codes, extremes, saturated counts
        queue_cmd(CMD_POP,   $urandom, 7'd127, 1'b0);
        queue_cmd(CMD_LIST,  $urandom, 7'd0,   1'b0);
        queue_cmd(CMD_TOP3,  $urandom, 7'd0,   1'b0);
        queue_cmd(CMD_BOT3,  $urandom, 7'd127, 1'b0);
        queue_cmd(CMD_POPN,  $urandom, 7'd0,   1'b0);
        queue_cmd(CMD_POPN,  $urandom, 7'd3,   1'b0);
        queue_cmd(CMD_RSVD6, $urandom, 7'd5,   1'b0);
        queue_cmd(CMD_RSVD7, $urandom, 7'd5,   1'b0);
        queue_cmd(CMD_PUSH,  32'sh7fffffff, 7'd0, 1'b0);
        queue_cmd(CMD_PUSH,  32'sh80000000, 7'd127, 1'b0);
        queue_cmd(CMD_TOP3,  $urandom, 7'd0,   1'b0);
        queue_cmd(CMD_BOT3,  $urandom, 7'd0,   1'b0);
        queue_cmd(CMD_PUSH,  -32'sd1, 7'd0,    1'b0);
        queue_cmd(CMD_TOP3,  $urandom, 7'd0,   1'b0);
        queue_cmd(CMD_BOT3,  $urandom, 7'd0,   1'b0);
        queue_cmd(CMD_PUSH,  32'sd0, 7'd0,     1'b0);
        queue_cmd(CMD_PUSH,  32'sh5555aaaa, 7'd0, 1'b0);
        queue_cmd(CMD_LIST,  $urandom, 7'd0,   1'b0);
        queue_cmd(CMD_POP,   $urandom, 7'd0,   1'b0);
        queue_cmd(CMD_POPN,  $urandom, 7'd2,   1'b0);
        queue_cmd(CMD_POPN,  $urandom, 7'd127, 1'b0);
        queue_cmd(CMD_POPN,  $urandom, 7'd64,  1'b0);
        queue_cmd(CMD_POPN,  $urandom, 7'd65,  1'b0);

        // fill to full, pushing past the top
        pushes = 0;
        while (pushes < STACK_DEPTH + 2) begin
            send_fast = (pushes >= 20 && pushes < 50);
            if ($urandom_range(0, 5) == 0) begin
                queue_cmd($urandom_range(0, 1) ? CMD_TOP3 : CMD_BOT3, $urandom,
                          CNT_W'($urandom_range(0, 127)), 1'b0);
            end else begin
                queue_cmd(CMD_PUSH, $urandom, CNT_W'($urandom_range(0, 127)), pushes == 0);
                pushes++;
            end
        end
        send_fast = 1'b0;
        queue_cmd(CMD_PUSH, $urandom, 7'd0, 1'b1);
        queue_cmd(CMD_LIST, $urandom, 7'd0, 1'b0);
        queue_cmd(CMD_TOP3, $urandom, 7'd0, 1'b0);
        queue_cmd(CMD_BOT3, $urandom, 7'd0, 1'b0);

        // random mix
        counted = 0;
        while (counted < 25) begin
            send_fast = (counted >= 8 && counted < 16);
            r   = $urandom_range(0, 19);
            cnt = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 127))
                                              : CNT_W'($urandom_range(0, 6));
            if (r < 8)
                queue_cmd(CMD_PUSH, $urandom, CNT_W'($urandom_range(0, 127)), 1'b0);
            else if (r < 11)
                queue_cmd(CMD_POP, $urandom, CNT_W'($urandom_range(0, 127)), 1'b0);
            else if (r < 13)
                queue_cmd(CMD_POPN, $urandom, cnt, 1'b0);
            else if (r < 15)
                queue_cmd(CMD_LIST, $urandom, CNT_W'($urandom_range(0, 127)), 1'b0);
            else if (r < 17)
                queue_cmd(CMD_TOP3, $urandom, CNT_W'($urandom_range(0, 127)), 1'b0);
            else if (r < 19)
                queue_cmd(CMD_BOT3, $urandom, CNT_W'($urandom_range(0, 127)), 1'b0);
            else
                queue_cmd($urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7, $urandom,
                          CNT_W'($urandom_range(0, 127)), 1'b0);
            if (r < 19)
                counted++;
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(stim_done && pending_results.size() == 0) && cycle_cnt < CYCLE_LIMIT)
            @(posedge i_clk);

        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("** lifo_stack_engine_top: FAILED **");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (err_cnt == 0 && pending_results.size() == 0)
                $display("** lifo_stack_engine_top: PASSED **");
            else
                $display("** lifo_stack_engine_top: FAILED **");
        end
        $finish;
    end

endmodule
